// File: hdl/wildcard_signature_scanner_unit_assert.svh
// Assertion macros for the wildcard signature scanner.
`ifndef WILDCARD_SIGNATURE_SCANNER_UNIT_ASSERT_SVH
`define WILDCARD_SIGNATURE_SCANNER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every clock edge out of reset.
`define WSS_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wss assertion failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define WSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wss assertion failed");

`else

`define WSS_ASSERT(label, clk, rst_n, ante, cons)
`define WSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/wss_pkg.sv
// Shared codes and types of the wildcard signature scanner.
`default_nettype none

package wss_pkg;

	// Command codes carried in the action field
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_LEN   = 2'd2;
	localparam logic [1:0] ACT_SCAN  = 2'd3;

	// Result kinds
	localparam logic KIND_MATCH   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Pattern store update, one per consumed command beat
	typedef struct packed {
		logic       load;
		logic       set_len;
		logic [2:0] slot;
		logic [4:0] pos;
		logic [7:0] data;
		logic [5:0] length;
	} pat_wr_t;

endpackage

`default_nettype wire

// File: hdl/wss_cmd_if.sv
// Command channel of the wildcard signature scanner.
`default_nettype none

interface wss_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [2:0] pattern_slot;
	logic [4:0] byte_position;
	logic [7:0] data_byte;
	logic [5:0] pattern_length;
	logic       end_of_region;

	modport source (
		output valid, action, pattern_slot, byte_position, data_byte,
			pattern_length, end_of_region,
		input  ready
	);
	modport sink (
		input  valid, action, pattern_slot, byte_position, data_byte,
			pattern_length, end_of_region,
		output ready
	);
endinterface

`default_nettype wire

// File: hdl/wss_res_if.sv
// Result channel of the wildcard signature scanner.
`default_nettype none

interface wss_res_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [2:0]  matched_slot;
	logic [31:0] match_offset;
	logic [7:0]  found_mask;
	logic        last;

	modport source (
		output valid, result_kind, matched_slot, match_offset, found_mask, last,
		input  ready
	);
	modport sink (
		input  valid, result_kind, matched_slot, match_offset, found_mask, last,
		output ready
	);
endinterface

`default_nettype wire

// File: hdl/wss_match.sv
// Pattern store, pattern lengths and the parallel window comparators.
`default_nettype none

module wss_match #(
	parameter int NUM_PATTERNS    = 8,
	parameter int MAX_PATTERN_LEN = 32
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wss_pkg::pat_wr_t                        wr,
	input  wire  [MAX_PATTERN_LEN-1:0][7:0]         window,
	input  wire  [$clog2(MAX_PATTERN_LEN+1)-1:0]    fill,
	input  wire  [NUM_PATTERNS-1:0]                 found,
	output logic [NUM_PATTERNS-1:0]                 hit,
	output logic [NUM_PATTERNS-1:0][$clog2(MAX_PATTERN_LEN+1)-1:0] lens
);

	localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
	localparam int IDX_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

	logic [NUM_PATTERNS-1:0][MAX_PATTERN_LEN-1:0][7:0] pat_q;
	logic [NUM_PATTERNS-1:0][LEN_W-1:0]                len_q;

	// Write pattern bytes; the store has no reset
	always_ff @(posedge clk) begin
		for (int s = 0; s < NUM_PATTERNS; s++) begin
			for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
				if (wr.load && (32'(wr.slot) == 32'(s)) && (32'(wr.pos) == 32'(j))) begin
					pat_q[s][j] <= wr.data;
				end
			end
		end
	end

	// Set pattern lengths, saturated to the window depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else begin
			for (int s = 0; s < NUM_PATTERNS; s++) begin
				if (wr.set_len && (32'(wr.slot) == 32'(s))) begin
					if (32'(wr.length) > 32'(MAX_PATTERN_LEN)) begin
						len_q[s] <= LEN_W'(MAX_PATTERN_LEN);
					end else begin
						len_q[s] <= LEN_W'(wr.length);
					end
				end
			end
		end
	end

	assign lens = len_q;

	// Compare each pattern byte j with the byte len-1-j steps back
	always_comb begin
		logic [31:0] d;
		logic        ok;
		hit = '0;
		for (int s = 0; s < NUM_PATTERNS; s++) begin
			ok = 1'b1;
			for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
				d = 32'(len_q[s]) - 32'(j) - 32'd1;
				if ((32'(j) < 32'(len_q[s])) && (pat_q[s][j] != 8'd0) &&
					(pat_q[s][j] != window[d[IDX_W-1:0]])) begin
					ok = 1'b0;
				end
			end
			hit[s] = ok && !found[s] && (len_q[s] != '0) && (len_q[s] <= fill);
		end
	end

endmodule

`default_nettype wire

// File: hdl/wildcard_signature_scanner_unit.sv
// Top level of the wildcard signature scanner: command stage, scan state, result burst.
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------------
//  cmd     | in  | action, slot, position, data byte, length, end of region
//  res     | out | result_kind, matched_slot, match_offset, found_mask, last
//
// A beat enters the command register and is consumed as it leaves it, where all
// comparators run at once against the shifted window; its results start right after.
// A scan byte with k matches yields k results, plus a summary when it ends the region,
// from the burst register at one per cycle while res is ready; cmd stalls only while
// such a byte waits for the previous burst to drain. Other beats pass at one per cycle.
// Reset clears lengths, found flags, window and offset; the pattern store is not reset.
`default_nettype none

`include "wildcard_signature_scanner_unit_assert.svh"

module wildcard_signature_scanner_unit #(
	parameter int NUM_PATTERNS    = 8,
	parameter int MAX_PATTERN_LEN = 32
) (
	input wire        clk,
	input wire        arst_n,
	wss_cmd_if.sink   cmd,
	wss_res_if.source res
);

	localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
	localparam int SLOT_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;

	// Command register
	logic        cmd_v_s1;
	logic [1:0]  action_s1;
	logic [2:0]  slot_s1;
	logic [4:0]  pos_s1;
	logic [7:0]  data_s1;
	logic [5:0]  length_s1;
	logic        end_s1;

	// Scan state
	logic [MAX_PATTERN_LEN-1:0][7:0] window_q;
	logic [LEN_W-1:0]                fill_q;
	logic [NUM_PATTERNS-1:0]         found_q;
	logic [31:0]                     offset_q;

	// Result burst
	logic [NUM_PATTERNS-1:0]            pend_q;
	logic                               sum_q;
	logic [NUM_PATTERNS-1:0]            hits_q;
	logic [NUM_PATTERNS-1:0]            fsnap_q;
	logic [31:0]                        base_q;
	logic [NUM_PATTERNS-1:0][LEN_W-1:0] lsnap_q;

	logic [MAX_PATTERN_LEN-1:0][7:0]    window_next;
	logic [LEN_W-1:0]                   fill_next;
	logic [NUM_PATTERNS-1:0]            hit;
	logic [NUM_PATTERNS-1:0][LEN_W-1:0] lens;
	wss_pkg::pat_wr_t                   wr;
	logic                               is_scan;
	logic                               emits;
	logic                               burst_free;
	logic                               s1_go;
	logic [SLOT_W-1:0]                  sel;
	logic [NUM_PATTERNS-1:0]            rest;
	logic [NUM_PATTERNS-1:0]            mask_wide;

	// Shift the incoming byte into the window and count fill
	always_comb begin
		window_next = window_q;
		for (int k = MAX_PATTERN_LEN - 1; k > 0; k--) begin
			window_next[k] = window_q[k-1];
		end
		window_next[0] = data_s1;
		if (32'(fill_q) < 32'(MAX_PATTERN_LEN)) begin
			fill_next = fill_q + LEN_W'(1);
		end else begin
			fill_next = fill_q;
		end
	end

	assign is_scan    = (action_s1 == wss_pkg::ACT_SCAN);
	assign emits      = is_scan && ((|hit) || end_s1);
	assign burst_free = !res.valid || (res.ready && res.last);
	assign s1_go      = cmd_v_s1 && (!emits || burst_free);
	assign cmd.ready  = !cmd_v_s1 || s1_go;

	// Drive pattern store updates when a command is consumed
	always_comb begin
		wr.load    = s1_go && (action_s1 == wss_pkg::ACT_LOAD);
		wr.set_len = s1_go && (action_s1 == wss_pkg::ACT_LEN);
		wr.slot    = slot_s1;
		wr.pos     = pos_s1;
		wr.data    = data_s1;
		wr.length  = length_s1;
	end

	wss_match #(
		.NUM_PATTERNS   (NUM_PATTERNS),
		.MAX_PATTERN_LEN(MAX_PATTERN_LEN)
	) u_match (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (wr),
		.window(window_next),
		.fill  (fill_next),
		.found (found_q),
		.hit   (hit),
		.lens  (lens)
	);

	// Capture command beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			cmd_v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			action_s1 <= cmd.action;
			slot_s1   <= cmd.pattern_slot;
			pos_s1    <= cmd.byte_position;
			data_s1   <= cmd.data_byte;
			length_s1 <= cmd.pattern_length;
			end_s1    <= cmd.end_of_region;
		end
	end

	// Advance scan state on each consumed start or scan command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
			found_q  <= '0;
			offset_q <= '0;
		end else if (s1_go) begin
			if (action_s1 == wss_pkg::ACT_START) begin
				found_q  <= '0;
				fill_q   <= '0;
				offset_q <= '0;
			end else if (is_scan) begin
				window_q <= window_next;
				found_q  <= found_q | hit;
				if (end_s1) begin
					fill_q   <= '0;
					offset_q <= '0;
				end else begin
					fill_q   <= fill_next;
					offset_q <= offset_q + 32'd1;
				end
			end
		end
	end

	// Pick the lowest pending slot
	always_comb begin
		sel = '0;
		for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel = SLOT_W'(i);
			end
		end
		for (int i = 0; i < NUM_PATTERNS; i++) begin
			rest[i] = pend_q[i] && (32'(i) != 32'(sel));
		end
	end

	// Form the result beat from the burst register
	always_comb begin
		res.valid = (|pend_q) || sum_q;
		if (|pend_q) begin
			for (int i = 0; i < NUM_PATTERNS; i++) begin
				mask_wide[i] = fsnap_q[i] || (hits_q[i] && (32'(i) <= 32'(sel)));
			end
			res.result_kind  = wss_pkg::KIND_MATCH;
			res.matched_slot = 3'(sel);
			res.match_offset = base_q - 32'(lsnap_q[sel]);
			res.last         = !(|rest) && !sum_q;
		end else begin
			mask_wide        = fsnap_q | hits_q;
			res.result_kind  = wss_pkg::KIND_SUMMARY;
			res.matched_slot = 3'd0;
			res.match_offset = 32'd0;
			res.last         = 1'b1;
		end
		res.found_mask = 8'd0;
		for (int b = 0; b < 8; b++) begin
			if (b < NUM_PATTERNS) begin
				res.found_mask[b] = mask_wide[b];
			end
		end
	end

	// Load a new burst or drop the beat just taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			sum_q  <= 1'b0;
		end else if (s1_go && emits) begin
			pend_q <= hit;
			sum_q  <= end_s1;
		end else if (res.valid && res.ready) begin
			if (|pend_q) begin
				pend_q <= rest;
			end else begin
				sum_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emits) begin
			hits_q  <= hit;
			fsnap_q <= found_q;
			base_q  <= offset_q + 32'd1;
			lsnap_q <= lens;
		end
	end

	// A result-producing byte enters the burst only once it has drained
	`WSS_ASSERT(burst_load_free, clk, arst_n, s1_go && emits, burst_free)

	// A match result already counts its own slot as found
	`WSS_ASSERT(match_in_mask, clk, arst_n,
		res.valid && (res.result_kind == wss_pkg::KIND_MATCH) && (NUM_PATTERNS <= 8),
		res.found_mask[res.matched_slot])

	// Found flags only clear on a start command
	`WSS_ASSERT_NEXT(found_sticky, clk, arst_n,
		!(s1_go && (action_s1 == wss_pkg::ACT_START)),
		(found_q & $past(found_q)) == $past(found_q))

endmodule

`default_nettype wire
